// File: design/bpa_pkg.sv
// Shared types and constants for the buddy page allocator.
// Used by bpa_ctrl, bpa_datapath and buddy_page_allocator; no dependencies.
`timescale 1ns / 1ps

package bpa_pkg;

  // Pool geometry: node 1 is the root, leaves are POOL_PAGES..2*POOL_PAGES-1
  localparam int POOL_PAGES = 1024;
  localparam int LOG2_POOL  = $clog2(POOL_PAGES);
  localparam int NODE_COUNT = 2 * POOL_PAGES;
  localparam int NODE_W     = LOG2_POOL + 1;
  localparam int VAL_W      = LOG2_POOL + 1;
  localparam int SUM_W      = VAL_W + 1;
  localparam int PROD_W     = NODE_W + VAL_W;

  // Field widths of the transfer payloads
  localparam int OFFSET_W = 10;
  localparam int PAGES_W  = 11;

  // Opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE          = 2'd0,
    ST_NO_SPACE      = 2'd1,
    ST_NOT_ALLOCATED = 2'd2
  } status_t;

  typedef struct packed {
    logic                opcode;
    logic [PAGES_W-1:0]  request_pages;
    logic [OFFSET_W-1:0] page_offset;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [OFFSET_W-1:0] block_offset;
    logic [PAGES_W-1:0]  block_pages;
    logic [PAGES_W-1:0]  largest_free;
  } rsp_t;

  // Commands from the controller to the datapath
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_START,
    CMD_DESC,
    CMD_CLIMB,
    CMD_UP,
    CMD_OUT
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_free;     // current operation is a free
    logic fail;        // request exceeds the root value
    logic claim;       // descent claims a node this cycle
    logic found;       // climb reached a claimed node
    logic root_hit;    // node under work is the root
    logic up_last;     // ascent writes the root this cycle
    logic clear_last;  // clearing pass writes its last node
  } dp_stat_t;

endpackage

// File: design/buddy_page_allocator.sv
// Top level of the buddy page allocator: controller plus datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.
//
//   Port group   Dir  Payload  Transfer when
//   req          in   req_t    req_valid && req_ready
//   rsp          out  rsp_t    rsp_valid && rsp_ready
//
// A failed allocation goes from its start step straight to done; otherwise it
// walks one tree level per cycle on the way down and again on the way up,
// paced by the node memory's single write port and registered read ports. A
// free climbs one level per cycle to the claimed node, then rewrites the
// ancestors above it, 11 levels in all. After reset a clearing pass writes
// nodes 1 to 2047 to load the tree; req_ready stays low until it ends. A
// result waiting in the output register stalls only the end of the next
// operation.
`timescale 1ns / 1ps

module buddy_page_allocator import bpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t     cmd;
  dp_stat_t stat;

  // Sequence the phases
  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Walk the tree
  bpa_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

// File: design/bpa_ctrl.sv
// Sequencer for the buddy page allocator: walks clear, descent, climb and ascent phases.
// Depends on bpa_pkg; drives bpa_datapath through cmd_t and reads dp_stat_t.
`timescale 1ns / 1ps

module bpa_ctrl import bpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_DESC,
    S_CLIMB,
    S_UP,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_next     = state;
    cmd            = CMD_NONE;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      S_CLEAR: begin
        cmd = CMD_CLEAR;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd = CMD_START;
        if (stat.is_free)   state_next = S_CLIMB;
        else if (stat.fail) state_next = S_DONE;
        else                state_next = S_DESC;
      end
      S_DESC: begin
        cmd = CMD_DESC;
        if (stat.claim) state_next = stat.root_hit ? S_DONE : S_UP;
      end
      S_CLIMB: begin
        cmd = CMD_CLIMB;
        if (stat.found)         state_next = stat.root_hit ? S_DONE : S_UP;
        else if (stat.root_hit) state_next = S_DONE;
      end
      S_UP: begin
        cmd = CMD_UP;
        if (stat.up_last) state_next = S_DONE;
      end
      S_DONE: begin
        // load the output register once the previous transfer has left
        if (!rsp_valid || rsp_ready) begin
          cmd            = CMD_OUT;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// File: design/bpa_datapath.sv
// Datapath of the buddy page allocator: node memory, walk registers and result register.
// Depends on bpa_pkg; sequenced by bpa_ctrl through cmd_t, reports dp_stat_t.
`timescale 1ns / 1ps

module bpa_datapath import bpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cmd_t     cmd,
  input  req_t     req,
  output dp_stat_t stat,
  output rsp_t     rsp
);

  // Node memory: one write port, two registered read ports
  logic [VAL_W-1:0] mem [NODE_COUNT];
  logic [VAL_W-1:0] rd_a, rd_b;
  logic [NODE_W-1:0] ra, rb, wa;
  logic [VAL_W-1:0]  wd;
  logic              we;

  // Clearing pass and root mirror
  logic [NODE_W-1:0] clr_addr;
  logic [VAL_W-1:0]  clr_val;
  logic [VAL_W-1:0]  root_val;

  // Operation and walk registers
  logic                 op_free;
  logic [PAGES_W-1:0]   want;
  logic [LOG2_POOL-1:0] page;
  logic [NODE_W-1:0]    node;
  logic [VAL_W-1:0]     nodeval;
  logic [VAL_W-1:0]     size;
  logic [VAL_W-1:0]     carry;
  logic [VAL_W-1:0]     span;
  logic                 merge;

  // Result registers
  status_t             res_status;
  logic [OFFSET_W-1:0] res_offset;
  logic [PAGES_W-1:0]  res_pages;

  // Combinational terms
  logic              go_left, go_right, claim_desc;
  logic [NODE_W-1:0] child, claim_node, up_node, mul_node;
  logic [VAL_W-1:0]  claim_size, span2, up_val, mul_size;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;

  // Descent: pick the left child if it fits, else the right, else stop here
  assign go_left    = PAGES_W'(rd_a) >= want;
  assign go_right   = !go_left && (PAGES_W'(rd_b) >= want);
  assign child      = {node[NODE_W-2:0], go_right};
  assign claim_desc = !(go_left || go_right) || child[NODE_W-1];
  assign claim_node = (go_left || go_right) ? child : node;
  assign claim_size = go_left ? rd_a : (go_right ? rd_b : nodeval);

  // Ascent: parent gets the larger child, or the full span when both are wholly free
  assign up_node = {1'b0, node[NODE_W-1:1]};
  assign span2   = {span[VAL_W-2:0], 1'b0};
  assign sum     = SUM_W'(carry) + SUM_W'(rd_a);
  assign up_val  = (merge && (sum == SUM_W'(span2))) ? span2 :
                   ((carry > rd_a) ? carry : rd_a);

  // Block offset: node * size less the leaf base
  assign mul_node = (cmd == CMD_DESC) ? claim_node : node;
  assign mul_size = (cmd == CMD_DESC) ? claim_size : size;
  assign prod     = PROD_W'(mul_node) * PROD_W'(mul_size);

  // Memory port selection
  always_comb begin
    we = 1'b0;
    wa = node;
    wd = '0;
    ra = node;
    rb = node;
    case (cmd)
      CMD_CLEAR: begin
        we = 1'b1;
        wa = clr_addr;
        wd = clr_val;
      end
      CMD_START: begin
        if (op_free) begin
          ra = {1'b1, page};
        end else begin
          ra = NODE_W'(2);
          rb = NODE_W'(3);
        end
      end
      CMD_DESC: begin
        if (claim_desc) begin
          we = 1'b1;
          wa = claim_node;
          ra = {claim_node[NODE_W-1:1], ~claim_node[0]};
        end else begin
          ra = {child[NODE_W-2:0], 1'b0};
          rb = {child[NODE_W-2:0], 1'b1};
        end
      end
      CMD_CLIMB: begin
        if (rd_a == '0) begin
          we = 1'b1;
          wa = node;
          wd = size;
          ra = {node[NODE_W-1:1], ~node[0]};
        end else begin
          ra = up_node;
        end
      end
      CMD_UP: begin
        we = 1'b1;
        wa = up_node;
        wd = up_val;
        ra = {up_node[NODE_W-1:1], ~up_node[0]};
      end
      default: ;
    endcase
  end

  // Status toward the controller
  always_comb begin
    stat.is_free    = op_free;
    stat.fail       = PAGES_W'(root_val) < want;
    stat.claim      = claim_desc;
    stat.found      = (rd_a == '0);
    stat.root_hit   = (cmd == CMD_DESC) ? (claim_node == NODE_W'(1)) : (node == NODE_W'(1));
    stat.up_last    = (up_node == NODE_W'(1));
    stat.clear_last = (clr_addr == '1);
  end

  // Node memory
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  // Clearing pass: each level holds half the value of the level above
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= NODE_W'(1);
      clr_val  <= VAL_W'(POOL_PAGES);
      root_val <= VAL_W'(POOL_PAGES);
    end else begin
      if (cmd == CMD_CLEAR) begin
        clr_addr <= clr_addr + NODE_W'(1);
        if ((clr_addr & (clr_addr + NODE_W'(1))) == '0) clr_val <= {1'b0, clr_val[VAL_W-1:1]};
      end
      if (we && (wa == NODE_W'(1))) root_val <= wd;
    end
  end

  // Walk and result registers
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op_free <= (req.opcode == OP_FREE);
        want    <= (req.request_pages == '0) ? PAGES_W'(1) : req.request_pages;
        page    <= req.page_offset[LOG2_POOL-1:0];
      end
      CMD_START: begin
        if (op_free) begin
          node <= {1'b1, page};
          size <= VAL_W'(1);
        end else begin
          node    <= NODE_W'(1);
          nodeval <= root_val;
          if (stat.fail) begin
            res_status <= ST_NO_SPACE;
            res_offset <= '0;
            res_pages  <= '0;
          end
        end
      end
      CMD_DESC: begin
        if (claim_desc) begin
          node       <= claim_node;
          carry      <= '0;
          span       <= claim_size;
          merge      <= 1'b0;
          res_status <= ST_DONE;
          res_offset <= OFFSET_W'(prod - PROD_W'(POOL_PAGES));
          res_pages  <= PAGES_W'(claim_size);
        end else begin
          node    <= child;
          nodeval <= go_left ? rd_a : rd_b;
        end
      end
      CMD_CLIMB: begin
        if (rd_a == '0) begin
          carry      <= size;
          span       <= size;
          merge      <= 1'b1;
          res_status <= ST_DONE;
          res_offset <= OFFSET_W'(prod - PROD_W'(POOL_PAGES));
          res_pages  <= PAGES_W'(size);
        end else if (node == NODE_W'(1)) begin
          res_status <= ST_NOT_ALLOCATED;
          res_offset <= '0;
          res_pages  <= '0;
        end else begin
          node <= up_node;
          size <= {size[VAL_W-2:0], 1'b0};
        end
      end
      CMD_UP: begin
        node  <= up_node;
        carry <= up_val;
        span  <= span2;
      end
      CMD_OUT: begin
        rsp.status       <= res_status;
        rsp.block_offset <= res_offset;
        rsp.block_pages  <= res_pages;
        rsp.largest_free <= PAGES_W'(root_val);
      end
      default: ;
    endcase
  end

endmodule
